// File: rtl/sso_pkg.sv
package sso_pkg;

   localparam int unsigned QW = 34;      // quotient and dividend stream width
   localparam int unsigned ACC_W = 33;

   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [17:0] THREE_Q16 = 18'd196608;
   localparam logic [30:0] RESET_ONE = 31'd65536;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_CENTER_X = 3'd0;
   localparam logic [2:0] REG_CENTER_Y = 3'd1;
   localparam logic [2:0] REG_CENTER_Z = 3'd2;
   localparam logic [2:0] REG_RAMP_START = 3'd3;
   localparam logic [2:0] REG_RAMP_END = 3'd4;
   localparam logic [2:0] REG_BOX_X = 3'd5;
   localparam logic [2:0] REG_BOX_Y = 3'd6;
   localparam logic [2:0] REG_BOX_Z = 3'd7;

   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   localparam logic [5:0] STEPS_R = 6'd16;
   localparam logic [5:0] STEPS_U = 6'd17;
   localparam logic [5:0] STEPS_MAG = 6'd34;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [30:0] ramp_start;
      logic [30:0] ramp_end;
      logic [30:0] box_x;
      logic [30:0] box_y;
      logic [30:0] box_z;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQX,
      OP_SQY,
      OP_SQZ,
      OP_SQRT,
      OP_RSEL,
      OP_RGET,
      OP_W1,
      OP_W2,
      OP_MCALC,
      OP_UDIV,
      OP_UGET,
      OP_MU,
      OP_MDIV,
      OP_GGET,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic [1:0] comp;
   } cmd_type;

   typedef struct packed {
      logic slab_ok;
      logic hard;
      logic need_div;
      logic d_zero;
      logic m_zero;
      logic div_busy;
      logic out_free;
   } sts_type;

   typedef struct packed {
      logic start;
      logic [31:0] rem_init;
      logic [QW-1:0] stream;
      logic [31:0] divisor;
      logic [5:0] steps;
   } div_req_type;

endpackage

// File: rtl/sso_div.sv
module sso_div (
   input  logic clock,
   input  logic reset,
   input  sso_pkg::div_req_type div_req,
   output logic busy,
   output logic [sso_pkg::QW-1:0] quot
);
   import sso_pkg::*;

   logic busy_ff, busy_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [QW-1:0] strm_ff, strm_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [32:0] rem2;
   logic [32:0] diff;
   logic ge;

   // Restoring division, one quotient bit per cycle. The remainder always
   // stays below the divisor, so 32 bits hold it.
   always_comb begin
      rem2 = {rem_ff, strm_ff[QW-1]};
      diff = rem2 - {1'b0, div_ff};
      ge = rem2 >= {1'b0, div_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      strm_in = strm_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = div_req.steps;
         rem_in = div_req.rem_init;
         div_in = div_req.divisor;
         strm_in = div_req.stream;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[31:0] : rem2[31:0];
         quot_in = {quot_ff[QW-2:0], ge};
         strm_in = {strm_ff[QW-2:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         busy_in = cnt_ff != 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      strm_ff <= strm_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

// File: rtl/sso_csr.sv
module sso_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [4:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready,
   output sso_pkg::cfg_type cfg
);
   import sso_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic [2:0] idx;
   logic wr;

   assign idx = csr_paddr[4:2];
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_CENTER_X:   cfg_in.center_x = csr_pwdata;
            REG_CENTER_Y:   cfg_in.center_y = csr_pwdata;
            REG_CENTER_Z:   cfg_in.center_z = csr_pwdata;
            REG_RAMP_START: cfg_in.ramp_start = csr_pwdata[30:0];
            REG_RAMP_END:   cfg_in.ramp_end = csr_pwdata[30:0];
            REG_BOX_X:      cfg_in.box_x = csr_pwdata[30:0];
            REG_BOX_Y:      cfg_in.box_y = csr_pwdata[30:0];
            REG_BOX_Z:      cfg_in.box_z = csr_pwdata[30:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_CENTER_X:   csr_prdata = cfg_ff.center_x;
         REG_CENTER_Y:   csr_prdata = cfg_ff.center_y;
         REG_CENTER_Z:   csr_prdata = cfg_ff.center_z;
         REG_RAMP_START: csr_prdata = {1'b0, cfg_ff.ramp_start};
         REG_RAMP_END:   csr_prdata = {1'b0, cfg_ff.ramp_end};
         REG_BOX_X:      csr_prdata = {1'b0, cfg_ff.box_x};
         REG_BOX_Y:      csr_prdata = {1'b0, cfg_ff.box_y};
         REG_BOX_Z:      csr_prdata = {1'b0, cfg_ff.box_z};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x <= '0;
         cfg_ff.center_y <= '0;
         cfg_ff.center_z <= '0;
         cfg_ff.ramp_start <= '0;
         cfg_ff.ramp_end <= RESET_ONE;
         cfg_ff.box_x <= RESET_ONE;
         cfg_ff.box_y <= RESET_ONE;
         cfg_ff.box_z <= RESET_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

endmodule

// File: rtl/sso_ctrl.sv
module sso_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  sso_pkg::sts_type sts,
   output sso_pkg::cmd_type cmd
);
   import sso_pkg::*;

   typedef enum logic [18:0] {
      ST_IDLE  = 19'h00001,
      ST_SQX   = 19'h00002,
      ST_SQY   = 19'h00004,
      ST_SQZ   = 19'h00008,
      ST_SQRT  = 19'h00010,
      ST_RSEL  = 19'h00020,
      ST_RWAIT = 19'h00040,
      ST_RGET  = 19'h00080,
      ST_W1    = 19'h00100,
      ST_W2    = 19'h00200,
      ST_MCALC = 19'h00400,
      ST_UDIV  = 19'h00800,
      ST_UWAIT = 19'h01000,
      ST_UGET  = 19'h02000,
      ST_MU    = 19'h04000,
      ST_MDIV  = 19'h08000,
      ST_MWAIT = 19'h10000,
      ST_GGET  = 19'h20000,
      ST_EMIT  = 19'h40000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] comp_ff, comp_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      comp_in = comp_ff;
      cmd.op = OP_NONE;
      cmd.comp = comp_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_LOAD;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            if (sts.slab_ok) begin
               cmd.op = OP_SQX;
               state_in = ST_SQY;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SQY: begin
            cmd.op = OP_SQY;
            state_in = ST_SQZ;
         end
         ST_SQZ: begin
            cmd.op = OP_SQZ;
            cnt_in = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = OP_SQRT;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_RSEL;
            end
         end
         ST_RSEL: begin
            cmd.op = OP_RSEL;
            if (sts.hard) begin
               state_in = ST_EMIT;
            end else if (sts.need_div) begin
               state_in = ST_RWAIT;
            end else begin
               state_in = ST_W1;
            end
         end
         ST_RWAIT: begin
            if (!sts.div_busy) begin
               state_in = ST_RGET;
            end
         end
         ST_RGET: begin
            cmd.op = OP_RGET;
            state_in = ST_W1;
         end
         ST_W1: begin
            cmd.op = OP_W1;
            state_in = ST_W2;
         end
         ST_W2: begin
            cmd.op = OP_W2;
            state_in = ST_MCALC;
         end
         ST_MCALC: begin
            cmd.op = OP_MCALC;
            comp_in = COMP_X;
            state_in = ST_UDIV;
         end
         ST_UDIV: begin
            if (sts.m_zero || sts.d_zero) begin
               state_in = ST_EMIT;
            end else begin
               cmd.op = OP_UDIV;
               state_in = ST_UWAIT;
            end
         end
         ST_UWAIT: begin
            if (!sts.div_busy) begin
               state_in = ST_UGET;
            end
         end
         ST_UGET: begin
            cmd.op = OP_UGET;
            state_in = ST_MU;
         end
         ST_MU: begin
            cmd.op = OP_MU;
            state_in = ST_MDIV;
         end
         ST_MDIV: begin
            cmd.op = OP_MDIV;
            state_in = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (!sts.div_busy) begin
               state_in = ST_GGET;
            end
         end
         ST_GGET: begin
            cmd.op = OP_GGET;
            if (comp_ff == COMP_Z) begin
               state_in = ST_EMIT;
            end else begin
               comp_in = comp_ff + 2'd1;
               state_in = ST_UDIV;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.op = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         comp_ff <= COMP_X;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         comp_ff <= comp_in;
      end
   end

endmodule

// File: rtl/sso_dp.sv
module sso_dp (
   input  logic clock,
   input  logic reset,
   input  sso_pkg::cfg_type cfg,
   input  sso_pkg::cmd_type cmd,
   output sso_pkg::sts_type sts,
   input  logic [15:0] req_atom_id,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic req_final_atom,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [15:0] rsp_atom_out,
   output logic rsp_in_slab,
   output logic [16:0] rsp_weight,
   output logic signed [31:0] rsp_grad_x,
   output logic signed [31:0] rsp_grad_y,
   output logic signed [31:0] rsp_grad_z,
   output logic [32:0] rsp_total_weight,
   output logic rsp_frame_done
);
   import sso_pkg::*;

   function automatic logic in_range(input logic [33:0] v);
      in_range = (v[33:31] == 3'b000) || ((v[33:31] == 3'b111) && (v[30:0] != '0));
   endfunction

   function automatic logic [30:0] abs31(input logic [33:0] v);
      logic [33:0] n;
      n = -v;
      abs31 = v[33] ? n[30:0] : v[30:0];
   endfunction

   // Item registers.
   logic [15:0] id_ff, id_in;
   logic fin_ff, fin_in;
   logic slab_ff, slab_in;
   logic far_ff, far_in;
   logic [33:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [63:0] sq_ff, sq_in;
   logic [63:0] rad_ff, rad_in;
   logic [33:0] srem_ff, srem_in;
   logic [31:0] root_ff, root_in;
   logic [16:0] r_ff, r_in, m_ff, m_in, u_ff, u_in, w_ff, w_in;
   logic [33:0] t_ff, t_in;
   logic [33:0] prod_ff, prod_in;
   logic [31:0] gx_ff, gx_in, gy_ff, gy_in, gz_ff, gz_in;
   logic [ACC_W-1:0] acc_ff, acc_in;

   // Result registers.
   logic out_valid_ff, out_valid_in;
   logic [15:0] o_id_ff, o_id_in;
   logic o_slab_ff, o_slab_in;
   logic [16:0] o_w_ff, o_w_in;
   logic [31:0] o_gx_ff, o_gx_in, o_gy_ff, o_gy_in, o_gz_ff, o_gz_in;
   logic [ACC_W-1:0] o_tot_ff, o_tot_in;
   logic o_fin_ff, o_fin_in;

   div_req_type div_req;
   logic div_busy;
   logic [QW-1:0] quot;

   // Load-time geometry.
   logic signed [35:0] pz36, refz36, half36, lo36, hi36, dz36;
   logic signed [32:0] px33, py33, bx33, by33, wpx, wpy;
   logic signed [33:0] dx34, dy34;

   // Common terms.
   logic [30:0] ax, ay, az, ac;
   logic [30:0] delta;
   logic hard;
   logic [61:0] sqa;
   logic [35:0] rem_sh, trial;
   logic [51:0] wprod;
   logic [33:0] rp;
   logic [36:0] rp6;
   logic [33:0] comp_v;
   logic comp_pos;
   logic [31:0] gval;
   logic [QW-1:0] mag;
   logic [33:0] acc_sum;
   logic out_free;

   assign ax = abs31(dx_ff);
   assign ay = abs31(dy_ff);
   assign az = abs31(dz_ff);
   assign delta = cfg.ramp_end - cfg.ramp_start;
   assign hard = cfg.ramp_end <= cfg.ramp_start;
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      pz36 = {{4{req_pos_z[31]}}, req_pos_z};
      refz36 = {{4{cfg.center_z[31]}}, cfg.center_z} + {6'd0, cfg.box_z[30:1]};
      half36 = {5'd0, cfg.ramp_end};
      lo36 = refz36 - half36;
      hi36 = refz36 + half36;
      dz36 = pz36 - refz36;
      px33 = {req_pos_x[31], req_pos_x};
      py33 = {req_pos_y[31], req_pos_y};
      bx33 = {2'd0, cfg.box_x};
      by33 = {2'd0, cfg.box_y};
      // The position is wrapped into the box once, not folded repeatedly.
      if (px33 < 0) begin
         wpx = px33 + bx33;
      end else if (px33 > bx33) begin
         wpx = px33 - bx33;
      end else begin
         wpx = px33;
      end
      if (py33 < 0) begin
         wpy = py33 + by33;
      end else if (py33 > by33) begin
         wpy = py33 - by33;
      end else begin
         wpy = py33;
      end
      dx34 = {wpx[32], wpx} - {{2{cfg.center_x[31]}}, cfg.center_x};
      dy34 = {wpy[32], wpy} - {{2{cfg.center_y[31]}}, cfg.center_y};
   end

   always_comb begin
      case (cmd.comp)
         COMP_X:  comp_v = dx_ff;
         COMP_Y:  comp_v = dy_ff;
         default: comp_v = dz_ff;
      endcase
      ac = abs31(comp_v);
      comp_pos = !comp_v[33] && (comp_v != '0);
   end

   always_comb begin
      case (cmd.op)
         OP_SQX:  sqa = ax * ax;
         OP_SQY:  sqa = ay * ay;
         default: sqa = az * az;
      endcase
   end

   always_comb begin
      rem_sh = {srem_ff, rad_ff[63:62]};
      trial = {2'd0, root_ff, 2'b01};
      wprod = t_ff * (THREE_Q16 - {r_ff, 1'b0});
      rp = r_ff * (ONE_Q16 - r_ff);
      rp6 = {1'b0, rp, 2'b00} + {2'b00, rp, 1'b0};
      mag = quot;
      // The gradient points against the offset and saturates to 32 bits.
      if (mag == '0) begin
         gval = '0;
      end else if (comp_pos) begin
         gval = (mag > 34'h080000000) ? 32'h80000000 : (~mag[31:0] + 32'd1);
      end else begin
         gval = (mag > 34'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
      end
      acc_sum = {1'b0, acc_ff} + {17'd0, w_ff};
   end

   always_comb begin
      id_in = id_ff;
      fin_in = fin_ff;
      slab_in = slab_ff;
      far_in = far_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      dz_in = dz_ff;
      sq_in = sq_ff;
      rad_in = rad_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      r_in = r_ff;
      m_in = m_ff;
      u_in = u_ff;
      w_in = w_ff;
      t_in = t_ff;
      prod_in = prod_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      gz_in = gz_ff;
      acc_in = acc_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      o_id_in = o_id_ff;
      o_slab_in = o_slab_ff;
      o_w_in = o_w_ff;
      o_gx_in = o_gx_ff;
      o_gy_in = o_gy_ff;
      o_gz_in = o_gz_ff;
      o_tot_in = o_tot_ff;
      o_fin_in = o_fin_ff;
      div_req.start = 1'b0;
      div_req.rem_init = '0;
      div_req.stream = '0;
      div_req.divisor = {1'b0, delta};
      div_req.steps = STEPS_R;

      case (cmd.op)
         OP_LOAD: begin
            id_in = req_atom_id;
            fin_in = req_final_atom;
            slab_in = (pz36 > lo36) && (pz36 < hi36);
            dx_in = dx34;
            dy_in = dy34;
            dz_in = dz36[33:0];
            far_in = !(in_range(dx34) && in_range(dy34));
            w_in = '0;
            r_in = '0;
            m_in = '0;
            gx_in = '0;
            gy_in = '0;
            gz_in = '0;
         end
         OP_SQX: sq_in = {2'd0, sqa};
         OP_SQY: sq_in = sq_ff + {2'd0, sqa};
         OP_SQZ: begin
            rad_in = sq_ff + {2'd0, sqa};
            srem_in = '0;
            root_in = '0;
         end
         OP_SQRT: begin
            // One root bit per cycle from the top pair of radicand bits.
            rad_in = {rad_ff[61:0], 2'b00};
            if (rem_sh >= trial) begin
               srem_in = rem_sh[33:0] - trial[33:0];
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               srem_in = rem_sh[33:0];
               root_in = {root_ff[30:0], 1'b0};
            end
         end
         OP_RSEL: begin
            if (hard) begin
               w_in = (root_ff <= {1'b0, cfg.ramp_start}) ? ONE_Q16 : '0;
            end
            r_in = (root_ff <= {1'b0, cfg.ramp_start}) ? '0 : ONE_Q16;
            if (sts.need_div) begin
               div_req.start = 1'b1;
               div_req.rem_init = root_ff - {1'b0, cfg.ramp_start};
               div_req.steps = STEPS_R;
            end
         end
         OP_RGET: r_in = {1'b0, quot[15:0]};
         OP_W1: t_in = r_ff * r_ff;
         OP_W2: w_in = ONE_Q16 - wprod[48:32];
         OP_MCALC: m_in = rp6[32:16];
         OP_UDIV: begin
            // The component never exceeds the distance, so the quotient fits 17 bits.
            div_req.start = 1'b1;
            div_req.rem_init = {2'd0, ac[30:1]};
            div_req.stream = {ac[0], 33'd0};
            div_req.divisor = root_ff;
            div_req.steps = STEPS_U;
         end
         OP_UGET: u_in = quot[16:0];
         OP_MU: prod_in = m_ff * u_ff;
         OP_MDIV: begin
            div_req.start = 1'b1;
            div_req.stream = prod_ff;
            div_req.steps = STEPS_MAG;
         end
         OP_GGET: begin
            case (cmd.comp)
               COMP_X:  gx_in = gval;
               COMP_Y:  gy_in = gval;
               default: gz_in = gval;
            endcase
         end
         OP_EMIT: begin
            out_valid_in = 1'b1;
            o_id_in = id_ff;
            o_slab_in = slab_ff;
            o_w_in = w_ff;
            o_gx_in = gx_ff;
            o_gy_in = gy_ff;
            o_gz_in = gz_ff;
            o_tot_in = acc_sum[33] ? '1 : acc_sum[32:0];
            o_fin_in = fin_ff;
            acc_in = fin_ff ? '0 : (acc_sum[33] ? '1 : acc_sum[32:0]);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         out_valid_ff <= out_valid_in;
      end
      id_ff <= id_in;
      fin_ff <= fin_in;
      slab_ff <= slab_in;
      far_ff <= far_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      dz_ff <= dz_in;
      sq_ff <= sq_in;
      rad_ff <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      r_ff <= r_in;
      m_ff <= m_in;
      u_ff <= u_in;
      w_ff <= w_in;
      t_ff <= t_in;
      prod_ff <= prod_in;
      gx_ff <= gx_in;
      gy_ff <= gy_in;
      gz_ff <= gz_in;
      o_id_ff <= o_id_in;
      o_slab_ff <= o_slab_in;
      o_w_ff <= o_w_in;
      o_gx_ff <= o_gx_in;
      o_gy_ff <= o_gy_in;
      o_gz_ff <= o_gz_in;
      o_tot_ff <= o_tot_in;
      o_fin_ff <= o_fin_in;
   end

   sso_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .busy    (div_busy),
      .quot    (quot)
   );

   always_comb begin
      sts.slab_ok = slab_ff && !far_ff;
      sts.hard = hard;
      sts.need_div = !hard && (root_ff > {1'b0, cfg.ramp_start})
                     && (root_ff < {1'b0, cfg.ramp_end});
      sts.d_zero = root_ff == '0;
      sts.m_zero = m_ff == '0;
      sts.div_busy = div_busy;
      sts.out_free = out_free;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_atom_out = o_id_ff;
   assign rsp_in_slab = o_slab_ff;
   assign rsp_weight = o_w_ff;
   assign rsp_grad_x = o_gx_ff;
   assign rsp_grad_y = o_gy_ff;
   assign rsp_grad_z = o_gz_ff;
   assign rsp_total_weight = o_tot_ff;
   assign rsp_frame_done = o_fin_ff;

endmodule

// File: rtl/sphere_smoothstep_occupancy.sv
// Smoothstep occupancy of a sphere inside a z slab, Q16.16 fixed point.
// The req_ channel takes one atom position per item; the rsp_ channel returns
// one result item per atom with its weight, gradient and the running weight
// sum, which is cleared after the item marked final_atom.
// Both channels use valid/ready; the csr_ port is an APB-style register port
// with eight 32-bit registers at byte addresses 0 to 28, always ready.
// One item is in work at a time. An atom outside the slab, or too far away in
// x or y, goes from the load step through the slab check to the emit step. A
// counted atom runs a square root, a division for the ramp coordinate where
// needed, and per gradient component two divisions on the shared restoring
// divider. Hard-step ramps stop after the square root and ramp selection; a
// zero distance or a zero ramp slope skips the gradient divisions.
// The result sits in an output register; a new item is accepted while it
// waits, and a stalled receiver only holds the block at its final step.
// Reset clears the weight sum and the result valid flag and loads the register
// defaults; no item is in work after reset.
module sphere_smoothstep_occupancy (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [15:0] req_atom_id,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic req_final_atom,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [15:0] rsp_atom_out,
   output logic rsp_in_slab,
   output logic [16:0] rsp_weight,
   output logic signed [31:0] rsp_grad_x,
   output logic signed [31:0] rsp_grad_y,
   output logic signed [31:0] rsp_grad_z,
   output logic [32:0] rsp_total_weight,
   output logic rsp_frame_done,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [4:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import sso_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   sso_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sso_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sso_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .sts              (sts),
      .req_atom_id      (req_atom_id),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_final_atom   (req_final_atom),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_atom_out     (rsp_atom_out),
      .rsp_in_slab      (rsp_in_slab),
      .rsp_weight       (rsp_weight),
      .rsp_grad_x       (rsp_grad_x),
      .rsp_grad_y       (rsp_grad_y),
      .rsp_grad_z       (rsp_grad_z),
      .rsp_total_weight (rsp_total_weight),
      .rsp_frame_done   (rsp_frame_done)
   );

endmodule
